// ===== rtl/tcce_pkg.sv =====
// shared constants, codes and control types for the text console cursor engine
package tcce_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // field widths
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;
    localparam int CLR_W  = 4;

    // internal widths
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int NC_W   = $clog2(COLUMNS + 4);
    localparam int ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int NR_W   = ROW_W + 1;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int SUM_W  = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

    localparam int TAB_STEP = 4;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F00;

    // commands
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // control bytes
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

    // register indexes
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    localparam int PADDR_W = 3;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic clear_step;
        logic sweep_step;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scroll;
        logic clear_last;
        logic row_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/tcce_ram.sv =====
// generic single write port ram with registered read
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tcce_datapath.sv =====
// cursor, screen ring base, sweep counter, screen store and result register
module tcce_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tcce_pkg::t_dp_cmd            i_cmd,
    output tcce_pkg::t_dp_sts            o_sts,
    input  logic                         i_command,
    input  logic [tcce_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcce_pkg::IDX_W-1:0]   i_cell_index,
    input  logic [tcce_pkg::CLR_W-1:0]   i_fg_color,
    input  logic [tcce_pkg::CLR_W-1:0]   i_bg_color,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [tcce_pkg::POS_W-1:0]   o_cursor_pos,
    output logic [tcce_pkg::CELL_W-1:0]  o_cell_data
);

    // latched item
    logic                          r_cmd;
    logic [tcce_pkg::CHAR_W-1:0]   r_char;
    logic [tcce_pkg::IDX_W-1:0]    r_idx;

    // cursor and ring base (physical address of logical row 0)
    logic [tcce_pkg::COL_W-1:0]    r_col;
    logic [tcce_pkg::ROW_W-1:0]    r_row;
    logic [tcce_pkg::ADDR_W-1:0]   r_base;

    // blanking sweep
    logic [tcce_pkg::ADDR_W-1:0]   r_sw_cnt;
    logic [tcce_pkg::ADDR_W-1:0]   r_sw_addr;

    // result register
    logic                          r_out_valid;
    logic [tcce_pkg::POS_W-1:0]    r_out_pos;
    logic [tcce_pkg::CELL_W-1:0]   r_out_data;

    logic [tcce_pkg::NC_W-1:0]     n_col;
    logic [tcce_pkg::NR_W-1:0]     n_row;
    logic                          wr_cell;
    logic                          scroll;
    logic                          idx_ok;
    logic [tcce_pkg::ADDR_W-1:0]   lin;
    logic [tcce_pkg::SUM_W-1:0]    tgt_sum;
    logic [tcce_pkg::ADDR_W-1:0]   phys;
    logic [tcce_pkg::SUM_W-1:0]    base_sum;
    logic [tcce_pkg::ADDR_W-1:0]   n_base;

    logic                          ram_we;
    logic [tcce_pkg::ADDR_W-1:0]   ram_waddr;
    logic [tcce_pkg::CELL_W-1:0]   ram_wdata;
    logic                          ram_re;
    logic [tcce_pkg::CELL_W-1:0]   ram_rdata;

    // next cursor for a put
    always_comb begin
        n_col   = tcce_pkg::NC_W'(r_col);
        n_row   = tcce_pkg::NR_W'(r_row);
        wr_cell = 1'b0;
        case (r_char)
            tcce_pkg::CH_LF: begin
                n_col = '0;
                n_row = tcce_pkg::NR_W'(r_row) + 1'b1;
            end
            tcce_pkg::CH_TAB: begin
                n_col = tcce_pkg::NC_W'(r_col) + tcce_pkg::NC_W'(tcce_pkg::TAB_STEP);
            end
            tcce_pkg::CH_VT, tcce_pkg::CH_FF: begin
                n_row = tcce_pkg::NR_W'(r_row) + 1'b1;
            end
            tcce_pkg::CH_CR: begin
                n_col = '0;
            end
            default: begin
                wr_cell = 1'b1;
                n_col   = tcce_pkg::NC_W'(r_col) + 1'b1;
            end
        endcase
        // wrap to next line
        if (n_col >= tcce_pkg::NC_W'(tcce_pkg::COLUMNS)) begin
            n_col = '0;
            n_row = n_row + 1'b1;
        end
        scroll = (n_row >= tcce_pkg::NR_W'(tcce_pkg::ROWS));
    end

    // logical to physical address through the ring base
    assign lin     = tcce_pkg::ADDR_W'(int'(r_row) * tcce_pkg::COLUMNS + int'(r_col));
    assign idx_ok  = (tcce_pkg::SUM_W'(r_idx) < tcce_pkg::SUM_W'(tcce_pkg::CELLS));
    assign tgt_sum = ((r_cmd == tcce_pkg::CMD_READ) ? tcce_pkg::SUM_W'(r_idx)
                                                    : tcce_pkg::SUM_W'(lin))
                     + tcce_pkg::SUM_W'(r_base);
    assign phys    = (tgt_sum >= tcce_pkg::SUM_W'(tcce_pkg::CELLS))
                     ? tcce_pkg::ADDR_W'(tgt_sum - tcce_pkg::SUM_W'(tcce_pkg::CELLS))
                     : tcce_pkg::ADDR_W'(tgt_sum);

    assign base_sum = tcce_pkg::SUM_W'(r_base) + tcce_pkg::SUM_W'(tcce_pkg::COLUMNS);
    assign n_base   = (base_sum >= tcce_pkg::SUM_W'(tcce_pkg::CELLS))
                      ? '0 : tcce_pkg::ADDR_W'(base_sum);

    // memory ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = phys;
        ram_wdata = {i_bg_color, i_fg_color, r_char};
        if (i_cmd.clear_step) begin
            ram_we    = 1'b1;
            ram_waddr = r_sw_cnt;
            ram_wdata = tcce_pkg::BLANK_CELL;
        end else if (i_cmd.sweep_step) begin
            ram_we    = 1'b1;
            ram_waddr = r_sw_addr;
            ram_wdata = tcce_pkg::BLANK_CELL;
        end else if (i_cmd.exec && (r_cmd == tcce_pkg::CMD_PUT) && wr_cell) begin
            ram_we = 1'b1;
        end
    end

    assign ram_re = i_cmd.exec && (r_cmd == tcce_pkg::CMD_READ) && idx_ok;

    tcce_ram #(
        .WIDTH (tcce_pkg::CELL_W),
        .DEPTH (tcce_pkg::CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (phys),
        .o_rdata (ram_rdata)
    );

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd  <= i_command;
            r_char <= i_char_code;
            r_idx  <= i_cell_index;
        end
    end

    // cursor, base and sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_base    <= '0;
            r_sw_cnt  <= '0;
            r_sw_addr <= '0;
        end else begin
            if (i_cmd.exec && (r_cmd == tcce_pkg::CMD_PUT)) begin
                r_col <= n_col[tcce_pkg::COL_W-1:0];
                if (scroll) begin
                    r_row     <= tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1);
                    r_base    <= n_base;
                    // old top row becomes the new bottom row
                    r_sw_addr <= r_base;
                    r_sw_cnt  <= '0;
                end else begin
                    r_row <= n_row[tcce_pkg::ROW_W-1:0];
                end
            end else if (i_cmd.clear_step) begin
                r_sw_cnt <= r_sw_cnt + 1'b1;
            end else if (i_cmd.sweep_step) begin
                r_sw_cnt  <= r_sw_cnt + 1'b1;
                r_sw_addr <= r_sw_addr + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_pos  <= tcce_pkg::POS_W'(int'(r_row) * tcce_pkg::COLUMNS + int'(r_col));
            r_out_data <= ((r_cmd == tcce_pkg::CMD_READ) && idx_ok) ? ram_rdata : '0;
        end
    end

    assign o_sts.scroll     = (r_cmd == tcce_pkg::CMD_PUT) && scroll;
    assign o_sts.clear_last = (r_sw_cnt == tcce_pkg::ADDR_W'(tcce_pkg::CELLS - 1));
    assign o_sts.row_last   = (r_sw_cnt == tcce_pkg::ADDR_W'(tcce_pkg::COLUMNS - 1));
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_cursor_pos = r_out_pos;
    assign o_cell_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_cursor_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_col) < tcce_pkg::COLUMNS) && (int'(r_row) < tcce_pkg::ROWS))
        else $error("cursor outside the screen");

    a_base_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_base) < tcce_pkg::CELLS)
        else $error("ring base outside the store");
`endif

endmodule

// ===== rtl/tcce_ctrl.sv =====
// controller state machine: clearing pass, item sequencing, line blanking
module tcce_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tcce_pkg::t_dp_sts i_sts,
    output tcce_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_EXEC   = 5'b00100,
        S_SWEEP  = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.scroll ? S_SWEEP : S_RESULT;
            end
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.row_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

`ifndef NO_ASSERTIONS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && i_in_valid |=> (r_state == S_EXEC))
        else $error("accepted transfer not executed next cycle");

    a_scroll_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && i_sts.scroll |=> (r_state == S_SWEEP))
        else $error("scroll without line blanking");

    a_sweep_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) && i_sts.row_last |=> (r_state == S_RESULT))
        else $error("line blanking did not end at the row boundary");
`endif

endmodule

// ===== rtl/text_console_cursor_engine.sv =====
// text console cursor engine: top level with apb color registers
//
// usage
//   input channel: i_in_valid / o_in_stall carries one item per transfer
//   (i_command, i_char_code, i_cell_index). a put command (0) prints a byte
//   or applies tab, newline, vertical tab, form feed or carriage return; a
//   read command (1) returns one screen cell by linear index
//   output channel: o_out_valid / i_out_stall carries one result per item,
//   the linear cursor position and the cell word (zero for a put)
//   sequencing: each item passes the exec and result states; the next item
//   is taken only once the last result is loaded into the output register; a
//   put that scrolls first blanks the new last line in the screen ram
//   the screen is a ring of rows: a scroll moves the base row and copies none
//   reset: the cursor goes home and a clearing pass writes blank cells to
//   all COLUMNS*ROWS entries with o_in_stall high; apb writes are taken
//   during the pass
//   a stalled result stays in the output register; the next item may be
//   accepted and processed meanwhile, its result waits until that register
//   is taken
//   apb: fg_color at 0x0, bg_color at 0x4, pready always high
module text_console_cursor_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_command,
    input  logic [tcce_pkg::CHAR_W-1:0]         i_char_code,
    input  logic [tcce_pkg::IDX_W-1:0]          i_cell_index,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [tcce_pkg::POS_W-1:0]          o_cursor_pos,
    output logic [tcce_pkg::CELL_W-1:0]         o_cell_data,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tcce_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    // color registers
    logic [tcce_pkg::CLR_W-1:0] r_fg;
    logic [tcce_pkg::CLR_W-1:0] r_bg;
    logic                       reg_sel;
    logic                       cfg_wr;

    tcce_pkg::t_dp_cmd dp_cmd;
    tcce_pkg::t_dp_sts dp_sts;

    // register index from the word address
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= tcce_pkg::CLR_W'(15);
            r_bg <= '0;
        end else if (cfg_wr) begin
            if (reg_sel == tcce_pkg::REG_FG) begin
                r_fg <= pwdata[tcce_pkg::CLR_W-1:0];
            end else begin
                r_bg <= pwdata[tcce_pkg::CLR_W-1:0];
            end
        end
    end

    // read back, zero extended
    assign prdata = (reg_sel == tcce_pkg::REG_FG) ? 32'(r_fg) : 32'(r_bg);

    tcce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    tcce_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_fg_color   (r_fg),
        .i_bg_color   (r_bg),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_data  (o_cell_data)
    );

endmodule

// ===== test/tcce_checker.sv =====
// result checker for the text console cursor engine: tracks colors, cursor and screen
`timescale 1ns / 1ps
module tcce_checker
    import tcce_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_command,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic [IDX_W-1:0]     i_cell_index,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [POS_W-1:0]     i_cursor_pos,
    input  logic [CELL_W-1:0]    i_cell_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_results,
    output int                   o_scrolls
);

    localparam int MAX_REPORTS = 60;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] data;
    } console_result_t;

    logic [CELL_W-1:0] screen_mirror [CELLS];
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [CLR_W-1:0]  fg_nibble;
    logic [CLR_W-1:0]  bg_nibble;
    console_result_t   cursor_results_q[$];
    console_result_t   want;
    int                fails;
    int                results;
    int                scrolls;

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
            screen_mirror[i] = BLANK_CELL;
    endfunction

    // apply one item to the mirrored console and return the result it causes
    function automatic console_result_t advance_console(logic cmd, logic [CHAR_W-1:0] ch,
                                                         logic [IDX_W-1:0] idx);
        console_result_t r;
        int              at;
        r.data = '0;
        if (cmd == CMD_PUT) begin
            case (ch)
                CH_LF: begin
                    cur_col = '0;
                    cur_row = cur_row + 1'b1;
                end
                CH_TAB: cur_col = cur_col + COL_W'(TAB_STEP);
                CH_VT, CH_FF: cur_row = cur_row + 1'b1;
                CH_CR: cur_col = '0;
                default: begin
                    at = int'(cur_row) * COLUMNS + int'(cur_col);
                    screen_mirror[at] = {bg_nibble, fg_nibble, ch};
                    cur_col = cur_col + 1'b1;
                end
            endcase
            // wrap past the right edge
            if (cur_col >= COLUMNS) begin
                cur_col = '0;
                cur_row = cur_row + 1'b1;
            end
            // scroll up, last line blank in the default colors
            if (cur_row >= ROWS) begin
                for (int i = 0; i < CELLS - COLUMNS; i++)
                    screen_mirror[i] = screen_mirror[i + COLUMNS];
                for (int i = CELLS - COLUMNS; i < CELLS; i++)
                    screen_mirror[i] = BLANK_CELL;
                cur_row = ROW_W'(ROWS - 1);
                scrolls++;
            end
        end else if (idx < CELLS) begin
            r.data = screen_mirror[idx];
        end
        r.pos = POS_W'(int'(cur_row) * COLUMNS + int'(cur_col));
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blank_screen();
            cur_col = '0;
            cur_row = '0;
            fg_nibble = 4'hF;
            bg_nibble = 4'h0;
            cursor_results_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == {REG_FG, 2'b00})
                    fg_nibble = pwdata[CLR_W-1:0];
                else if (paddr == {REG_BG, 2'b00})
                    bg_nibble = pwdata[CLR_W-1:0];
            end
            // results leave before new items enter: no result leaves in the cycle its own item enters
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (cursor_results_q.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $error("result transfer with nothing expected: cursor_pos %0d cell_data %h",
                               i_cursor_pos, i_cell_data);
                end else begin
                    want = cursor_results_q.pop_front();
                    if (i_cursor_pos !== want.pos) begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $error("cursor_pos: expected %0d, actual %0d", want.pos, i_cursor_pos);
                    end
                    if (i_cell_data !== want.data) begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $error("cell_data: expected %h, actual %h", want.data, i_cell_data);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                cursor_results_q.push_back(advance_console(i_command, i_char_code, i_cell_index));
        end
        o_fail_count <= fails;
        o_pending    <= cursor_results_q.size();
        o_results    <= results;
        o_scrolls    <= scrolls;
    end

endmodule

// ===== test/tb_text_console_cursor_engine.sv =====
// testbench top for the text console cursor engine: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb_text_console_cursor_engine;
    import tcce_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / PHASES + 1;
    localparam int DRAIN_CYCLES = 16;      // settle margin after the last expected result
    localparam int LONG_HOLD    = 400;     // receiver hold-off for the pressure phase
    localparam int MAX_GAP      = 17;
    localparam int PRESSURE_PH  = 2;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_command;
    logic [CHAR_W-1:0]   i_char_code;
    logic [IDX_W-1:0]    i_cell_index;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [POS_W-1:0]    o_cursor_pos;
    logic [CELL_W-1:0]   o_cell_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int fail_count;
    int pending;
    int result_count;
    int scroll_count;
    int cycle_count = 0;

    // flow-control knobs for the sender and the receiver, set by the test sequence
    int send_gap_max;
    int recv_stall_max;
    int hold_request;

    int put_count;
    int read_count;
    int oor_read_count;

    text_console_cursor_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_data  (o_cell_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    tcce_checker u_console_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_cursor_pos (o_cursor_pos),
        .i_cell_data  (o_cell_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (result_count),
        .o_scrolls    (scroll_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle counter and watchdog; the limit covers the clearing pass, every item
    // waiting out the longest gap, stall and scroll, and the long hold-off, many times over
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("text_console_cursor_engine: mismatch");
        $finish;
    end

    // receiver: random stall before each result transfer, plus one long hold-off on request
    initial begin
        int stall_len;
        int hold_len;
        i_out_stall <= 1'b0;
        forever begin
            if (hold_request > 0) begin
                hold_len = hold_request;
                hold_request = 0;
                i_out_stall <= 1'b1;
                // count the hold-off here so it does not depend on the sender
                repeat (hold_len) @(posedge i_clk);
            end
            stall_len = $urandom_range(0, recv_stall_max);
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // one input transfer after a random gap; valid stays high across back-to-back items
    task automatic send_item(input logic cmd, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] idx);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_char_code  <= ch;
        i_cell_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
        if (cmd == CMD_PUT) begin
            put_count++;
        end else begin
            read_count++;
            if (idx >= CELLS)
                oor_read_count++;
        end
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_item(CMD_PUT, ch, IDX_W'($urandom));
    endtask

    task automatic read_cell(input logic [IDX_W-1:0] idx);
        send_item(CMD_READ, CHAR_W'($urandom), idx);
    endtask

    // setup then access phase; psel then drops for an idle wait so back-to-back writes stay clean
    task automatic write_color(input logic reg_sel, input logic [CLR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {28'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering, wait for every expected result, then let the pipe settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly random byte values with a fair share of control bytes, reads spread over
    // the whole store and a tail of indexes past the last cell
    task automatic random_item(input int read_pct);
        int roll;
        int sub;
        roll = $urandom_range(0, 99);
        sub  = $urandom_range(0, 99);
        if (roll >= read_pct) begin
            if (sub < 9)
                put_char(CH_LF);
            else if (sub < 14)
                put_char(CH_TAB);
            else if (sub < 16)
                put_char(CH_VT);
            else if (sub < 18)
                put_char(CH_FF);
            else if (sub < 21)
                put_char(CH_CR);
            else
                put_char(CHAR_W'($urandom_range(0, 255)));
        end else begin
            if (sub < 85)
                read_cell(IDX_W'($urandom_range(0, CELLS - 1)));
            else
                read_cell(IDX_W'($urandom_range(CELLS, (1 << IDX_W) - 1)));
        end
    endtask

    initial begin
        int send_max_tbl [PHASES] = '{MAX_GAP, 0, 0, MAX_GAP, 0, MAX_GAP};
        int recv_max_tbl [PHASES] = '{MAX_GAP, 0, MAX_GAP, 0, MAX_GAP, MAX_GAP};
        int read_pct_tbl [PHASES] = '{30, 20, 25, 45, 15, 35};
        logic [CLR_W-1:0] fg_tbl [PHASES] = '{4'h0, 4'hF, 4'h3, 4'h0, 4'hF, 4'h9};
        logic [CLR_W-1:0] bg_tbl [PHASES] = '{4'hF, 4'h0, 4'hC, 4'h0, 4'hF, 4'h6};

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_command    <= CMD_PUT;
        i_char_code  <= '0;
        i_cell_index <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        send_gap_max   = MAX_GAP;
        recv_stall_max = MAX_GAP;
        hold_request   = 0;
        put_count      = 0;
        read_count     = 0;
        oor_read_count = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // colors written while the clearing pass still runs
        write_color(REG_FG, 4'hA);
        write_color(REG_BG, 4'h5);

        // directed: byte extremes, every control byte, read extremes
        put_char(8'h48);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h80);
        put_char(8'h7F);
        put_char(CH_TAB);
        put_char(8'h20);
        put_char(CH_CR);
        put_char(8'h41);            // overwrites column 0 after the return
        put_char(CH_LF);
        put_char(CH_VT);
        put_char(CH_FF);
        put_char(8'h61);
        read_cell(IDX_W'(0));
        read_cell(IDX_W'(1));
        read_cell(IDX_W'(2));
        read_cell(IDX_W'(3));
        read_cell(IDX_W'(3 * COLUMNS + 4));
        read_cell(IDX_W'(CELLS - 1));
        read_cell(IDX_W'(CELLS));  // first index past the store
        read_cell({IDX_W{1'b1}});
        read_cell(IDX_W'(1 << (IDX_W - 1)));
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_color(REG_FG, fg_tbl[ph]);
            write_color(REG_BG, bg_tbl[ph]);
            send_gap_max   = send_max_tbl[ph];
            recv_stall_max = recv_max_tbl[ph];
            // pressure: the receiver sits still while items keep coming back to back
            if (ph == PRESSURE_PH)
                hold_request = LONG_HOLD;
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item(read_pct_tbl[ph]);
            wait_idle();
        end

        $display("covered %0d puts and %0d reads (%0d past the last cell), %0d scrolls, %0d results",
                 put_count, read_count, oor_read_count, scroll_count, result_count);
        $display("%0d color settings incl. 0 and 15, gaps and stalls 0..%0d, one %0d-cycle hold-off",
                 PHASES + 1, MAX_GAP, LONG_HOLD);
        if (fail_count == 0)
            $display("text_console_cursor_engine: match");
        else
            $display("text_console_cursor_engine: mismatch");
        $finish;
    end

endmodule
